// ===== sv/nsw_pkg.sv =====
package nsw_pkg;

   localparam int DIGITS = 8;

   localparam logic [1:0] FUNC_UDEC = 2'd0;
   localparam logic [1:0] FUNC_SDEC = 2'd1;
   localparam logic [1:0] FUNC_HEX  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam logic [31:0] DEC_LIMIT   = 32'd99999999;
   localparam logic [31:0] NEG_BOUND   = 32'hFFFF_FFFF - 32'd9999999 + 32'd1;
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam logic [7:0]  MINUS_RESET = 8'h40;
   localparam logic [7:0]  POINT_BIT   = 8'h80;
   localparam logic [2:0]  CSR_MINUS   = 3'd0;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic [7:0]  dot_mask;
      logic [2:0]  start_position;
   } req_word_type;

   typedef struct packed {
      logic [3:0] ram_address;
      logic [7:0] segment_byte;
      logic       last;
   } rsp_word_type;

   // item as it travels down the digit cells
   typedef struct packed {
      logic        hex;
      logic        err;
      logic        minus;
      logic [3:0]  count;
      logic [7:0]  dots;
      logic [31:0] num;
      logic [63:0] segs;
   } tok_type;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      unique case (d)
         4'h0: g = 8'h3F;
         4'h1: g = 8'h06;
         4'h2: g = 8'h5B;
         4'h3: g = 8'h4F;
         4'h4: g = 8'h66;
         4'h5: g = 8'h6D;
         4'h6: g = 8'h7D;
         4'h7: g = 8'h07;
         4'h8: g = 8'h7F;
         4'h9: g = 8'h6F;
         4'hA: g = 8'h77;
         4'hB: g = 8'h7C;
         4'hC: g = 8'h39;
         4'hD: g = 8'h5E;
         4'hE: g = 8'h79;
         4'hF: g = 8'h71;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] err_glyph(input logic [2:0] i);
      logic [7:0] g;
      unique case (i)
         3'd0: g = 8'h79;
         3'd1: g = 8'h50;
         3'd2: g = 8'h50;
         3'd3: g = 8'h5C;
         3'd4: g = 8'h50;
         3'd5: g = 8'h00;
         3'd6: g = 8'h00;
         3'd7: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

// ===== sv/nsw_cell.sv =====
module nsw_cell
   import nsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  tok_type in_tok,
   output logic    out_valid,
   output tok_type out_tok
);

   logic [63:0] prod;
   logic [28:0] quot;
   logic [3:0]  q10_lo;
   logic [3:0]  digit;
   logic [7:0]  seg;
   tok_type     tok_in;
   tok_type     tok_ff;
   logic        valid_ff;

   always_comb begin
      prod   = {32'd0, in_tok.num} * {32'd0, RECIP10};
      quot   = prod[63:35];
      q10_lo = quot[0 +: 4] * 4'd10;
      digit  = in_tok.hex ? in_tok.num[3:0] : (in_tok.num[3:0] - q10_lo);
      seg    = glyph(digit) | (in_tok.dots[0] ? POINT_BIT : 8'h00);
      tok_in      = in_tok;
      tok_in.num  = in_tok.hex ? {4'd0, in_tok.num[31:4]} : {3'd0, quot};
      tok_in.dots = {1'b0, in_tok.dots[7:1]};
      tok_in.segs = {in_tok.segs[55:0], seg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

// ===== sv/nsw_writer.sv =====
module nsw_writer
   import nsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  tok_type      in_tok,
   input  logic [7:0]   minus_pattern,
   output logic         in_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic        busy_ff;
   logic [2:0]  idx_ff;
   logic [2:0]  last_idx_ff;
   logic [2:0]  last_idx_in;
   logic        err_ff;
   logic        minus_ff;
   logic [63:0] segs_ff;
   logic [2:0]  rev;
   logic        at_last;
   logic        done;
   logic        load;

   assign rev      = 3'(DIGITS - 1) - idx_ff;
   assign at_last  = idx_ff == last_idx_ff;
   assign done     = busy_ff && !rsp_stall && at_last;
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (in_tok.err) begin
         last_idx_in = 3'(DIGITS - 1);
      end else begin
         last_idx_in = 3'(in_tok.count - 4'd1) + {2'd0, in_tok.minus};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && !rsp_stall) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
      if (load) begin
         last_idx_ff <= last_idx_in;
         err_ff      <= in_tok.err;
         minus_ff    <= in_tok.minus;
         segs_ff     <= in_tok.segs;
      end
   end

   always_comb begin
      rsp_word.last = at_last;
      priority if (err_ff) begin
         rsp_word.ram_address  = {idx_ff, 1'b0};
         rsp_word.segment_byte = err_glyph(idx_ff);
      end else if (minus_ff && at_last) begin
         rsp_word.ram_address  = 4'd0;
         rsp_word.segment_byte = minus_pattern;
      end else begin
         rsp_word.ram_address  = {rev, 1'b0};
         rsp_word.segment_byte = segs_ff[{rev, 3'b000} +: 8];
      end
   end

   assign rsp_valid = busy_ff;

endmodule

// ===== sv/number_to_seven_segment_writes.sv =====
// Turns a number into display-RAM writes for an eight-digit seven-segment display.
// Input channel req_: one word carries func, value, dot_mask and start_position.
// Result channel rsp_: one word per RAM write (ram_address, segment_byte, last);
// last marks the final write of a number. func 3 is taken and yields nothing.
// Register minus_pattern reads at APB address 0 and is written at addresses 0 to 3
// (only paddr[2] is decoded on writes); pready is always high. An input word goes
// through an entry register and eight digit cells, one cell per cycle while the
// row advances; each cell pulls one digit off by a multiply-by-reciprocal, or by a
// four-bit shift for hex. The writer emits one write per cycle while rsp_stall is
// low; a number takes 1 to 8 writes (8 for errors, hex, signed values). Input
// words are accepted every cycle while the cell row has room, so the rate is set
// by the writer's write count. When rsp_stall is high the writer holds its word;
// once the last cell holds a word the writer cannot take, the row freezes and req_stall rises.
// Reset empties the row and the writer and sets minus_pattern to 0x40.
module number_to_seven_segment_writes
   import nsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic       negative;
   logic [7:0] minus_pattern_ff;
   logic       advance;
   logic       wr_ready;
   logic       entry_valid_ff;
   logic       entry_valid_in;
   tok_type    entry_tok_ff;
   tok_type    entry_tok_in;
   logic       cell_valid [DIGITS+1];
   tok_type    cell_tok [DIGITS+1];

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MINUS) ? {24'd0, minus_pattern_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         minus_pattern_ff <= MINUS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_MINUS[2]) begin
         minus_pattern_ff <= pwdata[7:0];
      end
   end

   assign advance   = !cell_valid[DIGITS] || wr_ready;
   assign req_stall = !advance;
   assign negative  = req_word.value[31];

   always_comb begin
      entry_valid_in     = req_valid && req_word.func != FUNC_NONE;
      entry_tok_in.hex   = 1'b0;
      entry_tok_in.err   = 1'b0;
      entry_tok_in.minus = 1'b0;
      entry_tok_in.count = 4'(DIGITS);
      entry_tok_in.dots  = req_word.dot_mask;
      entry_tok_in.num   = req_word.value;
      entry_tok_in.segs  = '0;
      unique case (req_word.func)
         FUNC_UDEC: begin
            entry_tok_in.err   = req_word.value > DEC_LIMIT;
            entry_tok_in.count = 4'(DIGITS) - {1'b0, req_word.start_position};
         end
         FUNC_SDEC: begin
            if (negative) begin
               entry_tok_in.err   = req_word.value < NEG_BOUND;
               entry_tok_in.minus = 1'b1;
               entry_tok_in.count = 4'(DIGITS - 1);
               entry_tok_in.num   = 32'd0 - req_word.value;
            end else begin
               entry_tok_in.err = req_word.value > DEC_LIMIT;
            end
         end
         FUNC_HEX: begin
            entry_tok_in.hex = 1'b1;
         end
         FUNC_NONE: begin
            entry_tok_in.err = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= entry_valid_in;
      end
      if (advance) begin
         entry_tok_ff <= entry_tok_in;
      end
   end

   assign cell_valid[0] = entry_valid_ff;
   assign cell_tok[0]   = entry_tok_ff;

   for (genvar k = 0; k < DIGITS; k++) begin : g_cell
      nsw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[k]),
         .in_tok    (cell_tok[k]),
         .out_valid (cell_valid[k+1]),
         .out_tok   (cell_tok[k+1])
      );
   end

   nsw_writer u_writer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cell_valid[DIGITS]),
      .in_tok        (cell_tok[DIGITS]),
      .minus_pattern (minus_pattern_ff),
      .in_ready      (wr_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word)
   );

   a_entry_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.func != FUNC_NONE |=> entry_valid_ff)
      else $error("accepted word did not enter the cell row");

   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      cell_valid[DIGITS] && !wr_ready |-> req_stall)
      else $error("cell row advanced while the writer was full");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word.last && !cell_valid[DIGITS] |=> !rsp_valid)
      else $error("writer kept going after the last write");

endmodule
